// ===== src/dmrct_pkg.sv =====
package dmrct_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_CACHE_ENABLE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE_LOG2  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT_LOG2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EXTRA_BLOCKS     = 2'd3;

    // limits on the decoded geometry
    localparam logic [4:0] BS_LOG2_MAX = 5'd16;
    localparam logic [2:0] BC_LOG2_MAX = 3'd5;

    // result kinds
    localparam logic [1:0] KIND_FILL   = 2'd0;
    localparam logic [1:0] KIND_COPY   = 2'd1;
    localparam logic [1:0] KIND_BYPASS = 2'd2;

    localparam int TAG_W = 8;

    typedef struct packed {
        logic [31:0] read_address;
        logic [19:0] read_length;
    } t_req;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] backing_address;
        logic [20:0] buffer_offset;
        logic [19:0] byte_count;
        logic        last;
    } t_res;

endpackage

// ===== src/dmrct_tag_ram.sv =====
module dmrct_tag_ram #(
    parameter int DEPTH = 32,
    parameter int IDX_W = 5
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_rd_en,
    input  logic [IDX_W-1:0]          i_rd_idx,
    input  logic                      i_wr_en,
    input  logic [IDX_W-1:0]          i_wr_idx,
    input  logic [dmrct_pkg::TAG_W-1:0] i_wr_tag,
    output logic [dmrct_pkg::TAG_W-1:0] o_rd_tag,
    output logic                      o_rd_valid
);
    import dmrct_pkg::*;

    logic [TAG_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [TAG_W-1:0] r_rd_tag;
    logic             r_rd_valid;

    // tag storage, one read and one write port, registered read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_idx] <= i_wr_tag;
        end
        if (i_rd_en) begin
            r_rd_tag   <= mem[i_rd_idx];
            r_rd_valid <= r_valid[i_rd_idx];
        end
    end

    // an entry is valid once written; reset drops every entry at once
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_idx] <= 1'b1;
        end
    end

    assign o_rd_tag   = r_rd_tag;
    assign o_rd_valid = r_rd_valid;

endmodule

// ===== src/direct_mapped_read_cache_tags.sv =====
// Tag controller of a direct-mapped read cache. Raise start with a request
// while busy is low; the block answers with fill commands for the missing
// blocks, one a cycle, then a copy command, or with a single bypass read when
// the cache is off or the request does not fit the blocks. Every command is
// shown for exactly one cycle with o_valid high and cannot be held off, so the
// receiver must take it then. A cached request keeps busy high through the
// split and span decode states, one walk state per spanned block for its tag
// memory access, and the copy state; a new request can start only once busy
// has dropped, and a bypass or zero-length request ends after span. Tags need
// no clearing pass after reset: per-block valid bits clear at once.
module direct_mapped_read_cache_tags #(
    parameter int MAX_BLOCKS = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  dmrct_pkg::t_req                      i_req,
    output logic                                 o_valid,
    output dmrct_pkg::t_res                      o_res,
    input  logic                                 i_cfg_we,
    input  logic [dmrct_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [dmrct_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import dmrct_pkg::*;

    localparam int IDX_W  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int LEFT_W = $clog2(MAX_BLOCKS + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SPLIT,
        ST_SPAN,
        ST_WALK,
        ST_COPY
    } t_state;

    t_state r_state;

    // configuration
    logic       r_cache_enable;
    logic [4:0] r_bs_log2;
    logic [2:0] r_bc_log2;
    logic [5:0] r_extra;

    // request context
    t_req              r_req;
    logic [15:0]       r_offset;
    logic [4:0]        r_seg;
    logic [TAG_W-1:0]  r_page;
    logic [21:0]       r_sum;
    logic [31:0]       r_base;
    logic [20:0]       r_copy_off;
    logic [IDX_W-1:0]  r_blk;
    logic [LEFT_W-1:0] r_left;

    logic r_out_valid;
    t_res r_res;

    // decoded geometry
    logic [4:0]  w_bs;
    logic [2:0]  w_bc;
    logic [16:0] w_bsize;
    logic [6:0]  w_count;
    logic [6:0]  w_total_raw;
    logic [6:0]  w_total;
    logic [15:0] w_offset;
    logic [4:0]  w_seg;
    logic [TAG_W-1:0] w_page;
    logic [21:0] w_sum;
    logic [21:0] w_nseg;
    logic        w_fits;
    logic [31:0] w_base;
    logic [21:0] w_copy_off;
    logic [21:0] w_blk_off;

    // tag memory
    logic             w_rd_en;
    logic [IDX_W-1:0] w_rd_idx;
    logic             w_wr_en;
    logic [TAG_W-1:0] w_rd_tag;
    logic             w_rd_valid;
    logic             w_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cache_enable <= 1'b1;
            r_bs_log2      <= 5'd9;
            r_bc_log2      <= 3'd4;
            r_extra        <= 6'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_CACHE_ENABLE:     r_cache_enable <= i_cfg_data[0];
                CFG_BLOCK_SIZE_LOG2:  r_bs_log2      <= i_cfg_data[4:0];
                CFG_BLOCK_COUNT_LOG2: r_bc_log2      <= i_cfg_data[2:0];
                CFG_EXTRA_BLOCKS:     r_extra        <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        w_bs        = (r_bs_log2 > BS_LOG2_MAX) ? BS_LOG2_MAX : r_bs_log2;
        w_bc        = (r_bc_log2 > BC_LOG2_MAX) ? BC_LOG2_MAX : r_bc_log2;
        w_bsize     = 17'd1 << w_bs;
        w_count     = 7'd1 << w_bc;
        w_total_raw = w_count + {1'b0, r_extra};
        w_total     = (w_total_raw > 7'(MAX_BLOCKS)) ? 7'(MAX_BLOCKS) : w_total_raw;

        // split the address: offset in block, block index, page tag
        w_offset = r_req.read_address[15:0] & w_bsize[15:0] - 16'd1;
        w_seg    = 5'(r_req.read_address >> w_bs) & 5'(w_count - 7'd1);
        w_page   = TAG_W'(r_req.read_address >> (w_bs + 5'(w_bc)));
        w_sum    = (r_req.read_length == 20'd0) ? 22'd0
                 : 22'(w_offset) + 22'(r_req.read_length)
                   + 22'(w_bsize) - 22'd1;

        // span of the request in blocks, and whether it fits
        w_nseg     = r_sum >> w_bs;
        w_fits     = (23'(r_seg) + 23'(w_nseg)) <= 23'(w_total);
        w_base     = 32'(r_page) << (w_bs + 5'(w_bc));
        w_copy_off = (22'(r_seg) << w_bs) + 22'(r_offset);

        w_blk_off  = 22'(r_blk) << w_bs;
    end

    // read the first tag at the end of decode, then one tag ahead while walking
    always_comb begin
        w_rd_en  = 1'b0;
        w_rd_idx = r_blk + IDX_W'(1);
        if (r_state == ST_SPAN) begin
            w_rd_en  = r_cache_enable && w_fits && (w_nseg != 22'd0);
            w_rd_idx = IDX_W'(r_seg);
        end else if (r_state == ST_WALK) begin
            w_rd_en  = (r_left > LEFT_W'(1));
        end
    end

    assign w_hit   = w_rd_valid && (w_rd_tag == r_page);
    assign w_wr_en = (r_state == ST_WALK) && !w_hit;

    dmrct_tag_ram #(
        .DEPTH (MAX_BLOCKS),
        .IDX_W (IDX_W)
    ) u_tag_ram (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (w_rd_en),
        .i_rd_idx   (w_rd_idx),
        .i_wr_en    (w_wr_en),
        .i_wr_idx   (r_blk),
        .i_wr_tag   (r_page),
        .o_rd_tag   (w_rd_tag),
        .o_rd_valid (w_rd_valid)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (start) begin
                        r_req   <= i_req;
                        r_state <= ST_SPLIT;
                    end
                end
                ST_SPLIT: begin
                    r_offset <= w_offset;
                    r_seg    <= w_seg;
                    r_page   <= w_page;
                    r_sum    <= w_sum;
                    r_state  <= ST_SPAN;
                end
                ST_SPAN: begin
                    r_base     <= w_base;
                    r_copy_off <= w_copy_off[20:0];
                    r_blk      <= IDX_W'(r_seg);
                    r_left     <= LEFT_W'(w_nseg);
                    if (!r_cache_enable || !w_fits) begin
                        r_out_valid           <= 1'b1;
                        r_res.kind            <= KIND_BYPASS;
                        r_res.backing_address <= r_req.read_address;
                        r_res.buffer_offset   <= '0;
                        r_res.byte_count      <= r_req.read_length;
                        r_res.last            <= 1'b1;
                        r_state               <= ST_IDLE;
                    end else if (w_nseg == 22'd0) begin
                        r_out_valid           <= 1'b1;
                        r_res.kind            <= KIND_COPY;
                        r_res.backing_address <= '0;
                        r_res.buffer_offset   <= w_copy_off[20:0];
                        r_res.byte_count      <= r_req.read_length;
                        r_res.last            <= 1'b1;
                        r_state               <= ST_IDLE;
                    end else begin
                        r_state <= ST_WALK;
                    end
                end
                ST_WALK: begin
                    // miss: fill the block and retag it
                    if (!w_hit) begin
                        r_out_valid           <= 1'b1;
                        r_res.kind            <= KIND_FILL;
                        r_res.backing_address <= r_base + 32'(w_blk_off);
                        r_res.buffer_offset   <= w_blk_off[20:0];
                        r_res.byte_count      <= 20'(w_bsize);
                        r_res.last            <= 1'b0;
                    end
                    r_blk  <= r_blk + IDX_W'(1);
                    r_left <= r_left - LEFT_W'(1);
                    if (r_left == LEFT_W'(1)) begin
                        r_state <= ST_COPY;
                    end
                end
                ST_COPY: begin
                    r_out_valid           <= 1'b1;
                    r_res.kind            <= KIND_COPY;
                    r_res.backing_address <= '0;
                    r_res.buffer_offset   <= r_copy_off;
                    r_res.byte_count      <= r_req.read_length;
                    r_res.last            <= 1'b1;
                    r_state               <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy    = (r_state != ST_IDLE);
    assign o_valid = r_out_valid;
    assign o_res   = r_res;

endmodule

// ===== dv/direct_mapped_read_cache_tags_test.sv =====
module direct_mapped_read_cache_tags_test;
    timeunit 1ns;
    timeprecision 1ps;

    import dmrct_pkg::*;

    localparam int N_BLOCKS    = 32;
    localparam int STALL_LIMIT = 2000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    t_req                  i_req = '0;
    logic                  o_valid;
    t_res                  o_res;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // shadow copy of the registers and the tag store
    logic       cache_on = 1'b1;
    logic [4:0] bs_log2 = 5'd9;
    logic [2:0] bc_log2 = 3'd4;
    logic [5:0] ext_blocks = 6'd0;
    logic [7:0] page_tag [N_BLOCKS];
    logic       tag_valid [N_BLOCKS];

    t_req req_q[$];
    t_res cmd_q[$];
    int   idle_pct = 0;
    int   mismatches = 0;
    int   quiet_cycles = 0;

    direct_mapped_read_cache_tags #(
        .MAX_BLOCKS(N_BLOCKS)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_valid     (o_valid),
        .o_res       (o_res),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic void geometry(output int unsigned bs, output int unsigned bc,
                                     output int unsigned total);
        bs = 32'((bs_log2 > BS_LOG2_MAX) ? BS_LOG2_MAX : bs_log2);
        bc = 32'((bc_log2 > BC_LOG2_MAX) ? BC_LOG2_MAX : bc_log2);
        total = (32'd1 << bc) + ext_blocks;
        if (total > N_BLOCKS) total = N_BLOCKS;
    endfunction

    // work out the fill/copy/bypass commands of one request and update the tags
    function automatic void predict_commands(input t_req r);
        int unsigned bs, bc, total, bsize, offset, seg, nseg, page;
        logic [31:0] base;
        t_res c;
        t_res f;
        c = '0;
        c.byte_count = r.read_length;
        c.last = 1'b1;
        if (!cache_on) begin
            c.kind = KIND_BYPASS;
            c.backing_address = r.read_address;
            cmd_q.push_back(c);
            return;
        end
        geometry(bs, bc, total);
        bsize = 32'd1 << bs;
        offset = r.read_address & (bsize - 1);
        seg = (r.read_address >> bs) & ((32'd1 << bc) - 1);
        nseg = (r.read_length == 0) ? 0 : (offset + r.read_length + bsize - 1) >> bs;
        if (seg + nseg > total) begin
            c.kind = KIND_BYPASS;
            c.backing_address = r.read_address;
            cmd_q.push_back(c);
            return;
        end
        page = (r.read_address >> (bs + bc)) & 32'hFF;
        base = page << (bs + bc);
        for (int unsigned blk = seg; blk < seg + nseg; blk++) begin
            if (!tag_valid[blk] || page_tag[blk] != 8'(page)) begin
                f = '0;
                f.kind = KIND_FILL;
                f.backing_address = base + (blk << bs);
                f.buffer_offset = 21'(blk << bs);
                f.byte_count = 20'(bsize);
                cmd_q.push_back(f);
                page_tag[blk] = 8'(page);
                tag_valid[blk] = 1'b1;
            end
        end
        c.kind = KIND_COPY;
        c.buffer_offset = 21'((seg << bs) + offset);
        cmd_q.push_back(c);
    endfunction

    // mostly requests that fit the blocks, on a few pages so that tags hit
    function automatic t_req shaped_req();
        int unsigned bs, bc, total, bsize, seg, off, page, nseg;
        longint lo, hi;
        int pick;
        t_req r;
        geometry(bs, bc, total);
        bsize = 32'd1 << bs;
        pick = $urandom_range(99);
        r.read_address = $urandom;
        r.read_length = 20'($urandom);
        if (pick < 10) return r;
        seg = $urandom_range((32'd1 << bc) - 1);
        off = $urandom & (bsize - 1);
        page = (pick < 22) ? 255 : $urandom_range(3);
        r.read_address = ($urandom << (bs + bc + 8)) | (page << (bs + bc)) | (seg << bs) | off;
        if (pick < 18) begin
            r.read_length = '0;
            return r;
        end
        nseg = $urandom_range(1, total - seg);
        // one block too many: a bypass, unless the length clamp below cuts it short
        if (pick >= 88) nseg = total - seg + 1;
        lo = longint'(nseg - 1) * bsize - off + 1;
        hi = longint'(nseg) * bsize - off;
        if (hi > 20'hFFFFF) hi = 20'hFFFFF;
        if (lo < 1) lo = 1;
        if (lo > hi) lo = hi;
        r.read_length = 20'(lo + $urandom_range(32'(hi - lo)));
        return r;
    endfunction

    // driver: hold while busy, advance on acceptance
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) predict_commands(i_req);
            if (!start || !busy) begin
                if (req_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    start <= 1'b1;
                    i_req <= req_q.pop_front();
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && o_valid) begin
            if (cmd_q.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected command: kind %0d baddr %h boff %h count %0d last %0b",
                             o_res.kind, o_res.backing_address, o_res.buffer_offset,
                             o_res.byte_count, o_res.last);
                mismatches++;
            end else begin
                want = cmd_q.pop_front();
                if (o_res.kind !== want.kind ||
                    o_res.backing_address !== want.backing_address ||
                    o_res.buffer_offset !== want.buffer_offset ||
                    o_res.byte_count !== want.byte_count ||
                    o_res.last !== want.last) begin
                    if (mismatches < 10)
                        $display("mismatch: expected %0d %h %h %0d %0b got %0d %h %h %0d %0b",
                                 want.kind, want.backing_address, want.buffer_offset,
                                 want.byte_count, want.last, o_res.kind,
                                 o_res.backing_address, o_res.buffer_offset,
                                 o_res.byte_count, o_res.last);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic settle();
        do @(negedge i_clk);
        while (req_q.size() != 0 || start || busy || cmd_q.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_CACHE_ENABLE:     cache_on = val[0];
            CFG_BLOCK_SIZE_LOG2:  bs_log2 = val[4:0];
            CFG_BLOCK_COUNT_LOG2: bc_log2 = val[2:0];
            CFG_EXTRA_BLOCKS:     ext_blocks = val[5:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_geometry(input logic en, input logic [4:0] bs,
                                input logic [2:0] bc, input logic [5:0] ext);
        settle();
        write_reg(CFG_CACHE_ENABLE, CFG_DATA_W'(en));
        write_reg(CFG_BLOCK_SIZE_LOG2, CFG_DATA_W'(bs));
        write_reg(CFG_BLOCK_COUNT_LOG2, CFG_DATA_W'(bc));
        write_reg(CFG_EXTRA_BLOCKS, ext);
    endtask

    task automatic add_req(input logic [31:0] addr, input logic [19:0] len);
        t_req r;
        r.read_address = addr;
        r.read_length = len;
        req_q.push_back(r);
    endtask

    task automatic run_random(input int n, input int idle);
        idle_pct = idle;
        repeat (n) req_q.push_back(shaped_req());
        settle();
    endtask

    initial begin
        for (int i = 0; i < N_BLOCKS; i++) begin
            page_tag[i] = 8'hFF;
            tag_valid[i] = 1'b0;
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset geometry: 512-byte blocks, 16 of them
        add_req(32'h0000_0000, 20'd1);
        add_req(32'h0000_0000, 20'd1);
        add_req(32'h0000_0000, 20'd0);
        add_req(32'hFFFF_FFFF, 20'd1);
        add_req(32'hFFFF_FFFF, 20'hFFFFF);
        add_req(32'h0000_0000, 20'd8192);
        add_req(32'h0000_0001, 20'd8192);
        add_req(32'h0000_2000, 20'd512);
        add_req(32'h0000_01FF, 20'd2);
        add_req(32'hAAAA_5555, 20'h55555);
        add_req(32'h5555_AAAA, 20'hAAAAA);
        add_req(32'h0000_1E00, 20'd512);
        settle();

        set_geometry(1'b0, 5'd9, 3'd4, 6'd0);
        add_req(32'h1234_5678, 20'd0);
        add_req(32'h0000_0000, 20'd1);
        settle();

        // oversized fields clamp, total saturates
        set_geometry(1'b1, 5'd31, 3'd7, 6'd63);
        add_req(32'h0000_0000, 20'hFFFFF);
        add_req(32'hFFFF_FFFF, 20'd1);
        add_req(32'hFFFF_FFFF, 20'd2);
        settle();

        // one-byte blocks, a single mapped block
        set_geometry(1'b1, 5'd0, 3'd0, 6'd0);
        add_req(32'h0000_0005, 20'd1);
        add_req(32'h0000_0005, 20'd2);
        add_req(32'h0000_0006, 20'd0);
        settle();

        set_geometry(1'b1, 5'd9, 3'd4, 6'd0);
        run_random(50, 0);
        set_geometry(1'b1, 5'd0, 3'd0, 6'd63);
        run_random(50, 66);
        set_geometry(1'b1, 5'd31, 3'd7, 6'd63);
        run_random(50, 0);
        set_geometry(1'b0, 5'd5, 3'd2, 6'd3);
        run_random(50, 66);
        set_geometry(1'b1, 5'd2, 3'd3, 6'd5);
        run_random(50, 20);
        set_geometry(1'b1, 5'd16, 3'd1, 6'd7);
        run_random(50, 20);

        settle();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && cmd_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== direct_mapped_read_cache_tags.f =====
src/dmrct_pkg.sv
src/dmrct_tag_ram.sv
src/direct_mapped_read_cache_tags.sv
dv/direct_mapped_read_cache_tags_test.sv
